// ----- design/ghash_pkg.sv -----
// Shared types and constants for the GHASH accumulator.
package ghash_pkg;

    localparam int BLOCK_BITS     = 128;
    localparam int HALF_BITS      = 64;
    localparam int DIGIT_BITS_DEF = 8;
    localparam int VBYTES_W       = 5;
    localparam int NUM_BYTES      = BLOCK_BITS / 8;
    localparam int S_TDATA_W      = 136;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 64;

    localparam logic [7:0] GF_REDUCE_BYTE = 8'hE1;

    localparam logic [BLOCK_BITS-1:0] GF_REDUCE_POLY =
        {GF_REDUCE_BYTE, {(BLOCK_BITS-8){1'b0}}};

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [HALF_BITS-1:0]  half_t;

endpackage

// ----- design/ghash_cfg.sv -----
// APB register file holding the hash key.
module ghash_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ghash_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ghash_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ghash_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output ghash_pkg::block_t               hash_key
);
    import ghash_pkg::*;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    half_t key_high_reg;
    half_t key_low_reg;
    logic  wr_en;
    logic  sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    // registers sit on 8-byte boundaries; bit 3 picks the register
    assign sel    = paddr[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (wr_en) begin
            unique case (sel)
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            default:      prdata = '0;
        endcase
    end

    assign hash_key = {key_high_reg, key_low_reg};

endmodule

// ----- design/ghash_mult.sv -----
// Digit-serial GF(2^128) multiplier, DIGIT_BITS key bits per cycle.
module ghash_mult #(
    parameter int DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ghash_pkg::block_t operand,
    input  ghash_pkg::block_t hash_key,
    output logic              done,
    output ghash_pkg::block_t product
);
    import ghash_pkg::*;

    // DIGIT_BITS must divide 128 and be below 128
    localparam int STEPS = BLOCK_BITS / DIGIT_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    block_t           v_reg, v_next;
    block_t           r_reg, r_next;
    block_t           k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             lsb;

    // walk one key digit, most significant key bit first
    always_comb begin
        v_next = v_reg;
        r_next = r_reg;
        lsb    = 1'b0;
        for (int b = 0; b < DIGIT_BITS; b++) begin
            if (k_reg[BLOCK_BITS-1-b]) begin
                r_next = r_next ^ v_next;
            end
            lsb    = v_next[0];
            v_next = v_next >> 1;
            if (lsb) begin
                v_next = v_next ^ GF_REDUCE_POLY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= operand;
            r_reg <= '0;
            k_reg <= hash_key;
        end else if (busy_reg) begin
            v_reg <= v_next;
            r_reg <= r_next;
            k_reg <= k_reg << DIGIT_BITS;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

// ----- design/ghash_accumulator_unit.sv -----
// GHASH accumulator top level: stream in, digest out, APB key registers.
//
//  channel | direction | payload
//  s_      | in        | data_high, data_low, valid_bytes (tdata); last_block (tlast)
//  m_      | out       | digest_high, digest_low (tdata)
//  apb     | config    | hash_key_high at 0x0, hash_key_low at 0x8
//
// A block with a nonzero byte count is accepted, then walked through the multiplier
// one key digit at a time, and then finished in ST_EMIT.
// A block with a byte count of zero skips the multiplier and goes straight to ST_EMIT.
// The multiplier's shift loop over the key digits sets the length of a multiply.
// Reset is synchronous, active low; it clears the accumulator and the key.
// A held result on m_ stalls only the finish of a last block.
module ghash_accumulator_unit #(
    parameter int DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // [63:0] data_high, [127:64] data_low, [132:128] valid_bytes, rest zero
    input  logic [ghash_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] digest_high, [127:64] digest_low
    output logic [ghash_pkg::BLOCK_BITS-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ghash_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ghash_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ghash_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import ghash_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MULT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    block_t              accum_reg;
    logic                last_reg;
    block_t              m_data_reg;
    logic                m_valid_reg;

    block_t              hash_key;
    block_t              product;
    logic                mult_done;
    logic                mult_start;
    block_t              din;
    block_t              byte_mask;
    logic [VBYTES_W-1:0] vbytes;
    logic                s_fire;
    logic                emit_fire;

    ghash_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .hash_key (hash_key)
    );

    ghash_mult #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mult_start),
        .operand  (accum_reg ^ (din & byte_mask)),
        .hash_key (hash_key),
        .done     (mult_done),
        .product  (product)
    );

    assign din    = {s_tdata[HALF_BITS-1:0], s_tdata[BLOCK_BITS-1:HALF_BITS]};
    assign vbytes = s_tdata[BLOCK_BITS +: VBYTES_W];

    // byte 0 sits in the top bits; counts above 16 enable every byte
    always_comb begin
        for (int j = 0; j < NUM_BYTES; j++) begin
            byte_mask[BLOCK_BITS-1-8*j -: 8] =
                (VBYTES_W'(j) < vbytes) ? 8'hFF : 8'h00;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid & s_tready;
    assign mult_start = s_fire & (vbytes != '0);
    assign emit_fire  = (state_reg == ST_EMIT) & last_reg & (~m_valid_reg | m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = mult_start ? ST_MULT : ST_EMIT;
                end
            end
            ST_MULT: begin
                if (mult_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold while the previous digest is still waiting
                if (!last_reg || emit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            accum_reg   <= '0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                last_reg <= s_tlast;
            end
            if (mult_done) begin
                accum_reg <= product;
            end else if (emit_fire) begin
                accum_reg <= '0;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg <= accum_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg[HALF_BITS-1:0], m_data_reg[BLOCK_BITS-1:HALF_BITS]};

endmodule

// ----- design/ghash_chk.sv -----
// Port-level checker for the GHASH accumulator, bound to the top level.
module ghash_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic [ghash_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ghash_pkg::BLOCK_BITS-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);
    import ghash_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second block taken while one is in progress");

    a_mult_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[BLOCK_BITS +: VBYTES_W] != '0)
        |-> ##8 !s_tready)
        else $error("multiply finished too early");

endmodule

bind ghash_accumulator_unit ghash_chk u_ghash_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- sim/tb_ghash_accumulator_unit.sv -----
// Self-checking testbench for the GHASH accumulator: stream blocks in, compare digests out.
module tb_ghash_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ghash_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int NUM_ROWS     = 24;

    localparam logic [APB_ADDR_W-1:0] ADDR_HASH_KEY_HIGH = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_HASH_KEY_LOW  = 4'h8;

    localparam half_t ONES  = {HALF_BITS{1'b1}};
    localparam half_t ONE_H = 64'h8000_0000_0000_0000;  // x^0 in reflected order
    localparam half_t TOP_B = 64'hFF00_0000_0000_0000;

    typedef enum logic [1:0] {ROW_KEY, ROW_BLOCK} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        half_t      a;       // data_high or hash_key_high
        half_t      b;       // data_low or hash_key_low
        logic [4:0] nbytes;
        logic       last;
        logic       typed;   // digest below is the expected result
        block_t     digest;
    } plan_row_t;

    typedef struct {
        half_t high;
        half_t low;
    } digest_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BLOCK_BITS-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    block_t  hash_key = '0;
    block_t  running_y = '0;
    digest_t pending_digests[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      rx_hold = 0;
    bit      steady = 1'b0;

    plan_row_t plan [0:NUM_ROWS-1] = '{
        '{ROW_BLOCK, ONES, ONES, 5'd16, 1'b1, 1'b1, '0},
        '{ROW_BLOCK, ONES, ONES, 5'd0,  1'b1, 1'b1, '0},
        '{ROW_KEY,   ONE_H, 64'h0, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, ONES, ONES, 5'd16, 1'b1, 1'b1, {ONES, ONES}},
        '{ROW_BLOCK, ONES, ONES, 5'd1,  1'b1, 1'b1, {TOP_B, 64'h0}},
        '{ROW_BLOCK, ONES, ONES, 5'd8,  1'b1, 1'b1, {ONES, 64'h0}},
        '{ROW_BLOCK, ONES, ONES, 5'd9,  1'b1, 1'b1, {ONES, TOP_B}},
        '{ROW_BLOCK, ONES, ONES, 5'd15, 1'b1, 1'b1, {ONES, 64'hFFFF_FFFF_FFFF_FF00}},
        '{ROW_BLOCK, ONES, ONES, 5'd31, 1'b1, 1'b1, {ONES, ONES}},
        '{ROW_BLOCK, ONES, ONES, 5'd17, 1'b1, 1'b1, {ONES, ONES}},
        '{ROW_BLOCK, ONES, ONES, 5'd0,  1'b1, 1'b1, '0},
        '{ROW_BLOCK, 64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5, 5'd16, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, ONES, ONES, 5'd0, 1'b1, 1'b1,
          {64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5}},
        '{ROW_BLOCK, 64'h5A5A_5A5A_5A5A_5A5A, 64'h3C3C_3C3C_3C3C_3C3C, 5'd16, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, 64'h5A5A_5A5A_5A5A_5A5A, 64'h3C3C_3C3C_3C3C_3C3C, 5'd16, 1'b1, 1'b1, '0},
        '{ROW_BLOCK, 64'h0, 64'h0, 5'd16, 1'b1, 1'b1, '0},
        '{ROW_KEY,   ONES, ONES, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, ONE_H, 64'h0, 5'd16, 1'b1, 1'b1, {ONES, ONES}},
        '{ROW_BLOCK, ONES, ONES, 5'd16, 1'b1, 1'b0, '0},
        '{ROW_BLOCK, 64'h0, 64'h1, 5'd16, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd4, 1'b1, 1'b0, '0},
        '{ROW_KEY,   64'h0, 64'h1, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_BLOCK, ONES, ONES, 5'd16, 1'b1, 1'b0, '0},
        '{ROW_BLOCK, 64'h8000_0000_0000_0001, 64'hC3C3_C3C3_C3C3_C3C3, 5'd12, 1'b1, 1'b0, '0}
    };

    ghash_accumulator_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Multiply by the hash key in the reflected bit order: key bit 127 weighs x^0.
    function automatic block_t gf128_times_key(block_t a, block_t h);
        block_t acc = '0;
        block_t v = a;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            if (h[BLOCK_BITS-1-i]) begin
                acc ^= v;
            end
            if (v[0]) begin
                v = (v >> 1) ^ GF_REDUCE_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return acc;
    endfunction

    // Mostly short idle stretches, a few long ones.
    function automatic int idle_len();
        int r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic half_t random_half();
        int r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return ONES;
        end
        return {$urandom, $urandom};
    endfunction

    // Hold the stream until every digest is back and the last block has left the multiplier.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Two back-to-back APB writes: key high, then key low.
    task automatic write_hash_key(half_t key_high, half_t key_low);
        logic [APB_ADDR_W-1:0] addrs [2];
        half_t vals [2];
        addrs[0] = ADDR_HASH_KEY_HIGH;
        addrs[1] = ADDR_HASH_KEY_LOW;
        vals[0] = key_high;
        vals[1] = key_low;
        for (int k = 0; k < 2; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addrs[k];
            pwdata  <= vals[k];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hash_key = {key_high, key_low};
    endtask

    task automatic send_block(half_t dh, half_t dl, logic [4:0] nbytes, logic last,
                              logic typed, block_t typed_digest);
        int n;
        int gap;
        digest_t d;
        s_tdata  <= {3'b000, nbytes, dl, dh};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // advance the running hash for the accepted transaction
        n = (nbytes > 5'd16) ? 16 : int'(nbytes);
        if (n != 0) begin
            running_y = gf128_times_key(
                running_y ^ ({dh, dl} & ~({BLOCK_BITS{1'b1}} >> (8 * n))), hash_key);
        end
        if (last) begin
            if (typed) begin
                d.high = typed_digest[127:64];
                d.low  = typed_digest[63:0];
            end else begin
                d.high = running_y[127:64];
                d.low  = running_y[63:0];
            end
            pending_digests.push_back(d);
            running_y = '0;
        end
        gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Digest checker and sink-side backpressure.
    always @(posedge aclk) begin
        digest_t d;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digests.size() == 0) begin
                $error("unexpected digest %h", m_tdata);
                mismatches++;
            end else begin
                d = pending_digests.pop_front();
                if (m_tdata[63:0] !== d.high) begin
                    $error("digest_high: expected %h, got %h", d.high, m_tdata[63:0]);
                    mismatches++;
                end
                if (m_tdata[127:64] !== d.low) begin
                    $error("digest_low: expected %h, got %h", d.low, m_tdata[127:64]);
                    mismatches++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) begin
                rx_hold = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** ghash_accumulator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int sent;
        int msg_len;
        int r;
        logic [4:0] nbytes;
        half_t key_high;
        half_t key_low;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (plan[i].kind == ROW_KEY) begin
                wait_drained();
                write_hash_key(plan[i].a, plan[i].b);
            end else begin
                send_block(plan[i].a, plan[i].b, plan[i].nbytes, plan[i].last,
                           plan[i].typed, plan[i].digest);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                wait_drained();
                case ($urandom_range(0, 9))
                    0: begin key_high = '0;    key_low = '0;   end
                    1: begin key_high = ONES;  key_low = ONES; end
                    2: begin key_high = ONE_H; key_low = '0;   end
                    3: begin key_high = '0;    key_low = 64'h1; end
                    4: begin
                        {key_high, key_low} = block_t'(1) << $urandom_range(0, 127);
                    end
                    default: begin
                        key_high = {$urandom, $urandom};
                        key_low  = {$urandom, $urandom};
                    end
                endcase
                write_hash_key(key_high, key_low);
            end else if (r < 11) begin
                wait_drained();
            end
            steady = ($urandom_range(0, 9) == 0);

            r = $urandom_range(0, 99);
            if (r < 60) begin
                msg_len = $urandom_range(1, 4);
            end else if (r < 90) begin
                msg_len = $urandom_range(5, 12);
            end else begin
                msg_len = $urandom_range(13, 30);
            end

            for (int b = 0; b < msg_len; b++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    nbytes = 5'd16;
                end else if (r < 85) begin
                    nbytes = 5'($urandom_range(1, 15));
                end else if (r < 90) begin
                    nbytes = 5'd0;
                end else if (r < 95) begin
                    nbytes = 5'($urandom_range(17, 31));
                end else begin
                    nbytes = 5'($urandom_range(0, 31));
                end
                send_block(random_half(), random_half(), nbytes, b == msg_len - 1,
                           1'b0, '0);
                sent++;
            end
        end

        steady = 1'b0;
        wait_drained();
        if (mismatches == 0) begin
            $display("** ghash_accumulator_unit: PASSED **");
        end else begin
            $display("** ghash_accumulator_unit: FAILED **");
        end
        $finish;
    end

endmodule
